// ===== hw/rtl/i2a_pkg.sv =====
`timescale 1ns / 1ps

package i2a_pkg;

  // Format selector codes.
  localparam logic [2:0] CMD_SDEC32 = 3'd0;
  localparam logic [2:0] CMD_UDEC32 = 3'd1;
  localparam logic [2:0] CMD_HEX64L = 3'd2;
  localparam logic [2:0] CMD_HEX32L = 3'd3;
  localparam logic [2:0] CMD_HEX32U = 3'd4;

  // Binary width converted to decimal, and the BCD width that holds the result.
  localparam int BIN_W   = 32;
  localparam int BCD_DIG = 10;
  localparam int BCD_W   = 4 * BCD_DIG;
  localparam int CNT_W   = $clog2(BIN_W);

  // Index of the most significant digit position for each format.
  localparam logic [3:0] TOP_DEC   = 4'd9;
  localparam logic [3:0] TOP_HEX64 = 4'd15;
  localparam logic [3:0] TOP_HEX32 = 4'd7;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;

  typedef struct packed {
    logic start;
  } dab_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dab_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

// ===== hw/rtl/i2a_dabble.sv =====
`timescale 1ns / 1ps

module i2a_dabble (
  input  logic                            clk,
  input  logic                            rst,
  input  i2a_pkg::dab_ctl_t               ctl,
  input  logic [i2a_pkg::BIN_W-1:0]       bin,
  output logic [i2a_pkg::BCD_W-1:0]       bcd,
  output i2a_pkg::dab_sts_t               sts
);
  import i2a_pkg::*;

  logic [BIN_W-1:0] shreg;
  logic [BCD_W-1:0] acc;
  logic [BCD_W-1:0] corr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // Add-3 correction on every BCD digit before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIG; i++) begin
      if (acc[4*i +: 4] >= 4'd5) begin
        corr[4*i +: 4] = acc[4*i +: 4] + 4'd3;
      end else begin
        corr[4*i +: 4] = acc[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !ctl.start && busy && (cnt == CNT_W'(BIN_W - 1));
      if (ctl.start) begin
        shreg <= bin;
        acc   <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        acc   <= {corr[BCD_W-2:0], shreg[BIN_W-1]};
        shreg <= {shreg[BIN_W-2:0], 1'b0};
        cnt   <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(BIN_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign bcd      = acc;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ===== hw/rtl/integer_to_ascii_digits_core.sv =====
`timescale 1ns / 1ps

// Channel   Signals                    Direction  Meaning
// input     in_valid, in_stall,        in / out   one number and its format per transaction
//           cmd[2:0], value[63:0]
// output    out_valid, out_stall,      out / in   one ASCII character per transaction
//           ch[7:0], last
//
// Decimal: the accept, the shift-add-3 passes over all 32 bits, collecting the digits,
// skipping leading zeros (up to 9) one at a time and leaving the skip, a sign character
// when negative, then the characters in order; hex skips the conversion.
// Reset is synchronous and returns the sequencer to idle with no character pending.
// An output stall holds the character register and pauses the emit sequence; the input
// is stalled for the whole time a number is being worked on.

module integer_to_ascii_digits_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  ch,
  output logic        last
);
  import i2a_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state;
  logic [63:0]      digs;
  logic [3:0]       ptr;
  logic             neg;
  logic             upper;

  logic             accept;
  logic             out_free;
  logic             ch_load;
  logic [3:0]       cur;
  logic [BIN_W-1:0] mag;
  logic [BCD_W-1:0] bcd;
  dab_ctl_t         dctl;
  dab_sts_t         dsts;

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // The character register can take a new character when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign ch_load  = out_free && (state inside {ST_SIGN, ST_EMIT});
  assign cur      = digs[{ptr, 2'b00} +: 4];

  // Signed decimal converts the two's complement magnitude; the most negative value
  // maps onto itself, which is exactly 2147483648 as unsigned.
  assign mag = (cmd == CMD_SDEC32 && value[31]) ? (~value[31:0] + 32'd1) : value[31:0];

  assign dctl.start = accept && (cmd == CMD_SDEC32 || cmd == CMD_UDEC32);

  i2a_dabble u_dabble (
    .clk (clk),
    .rst (rst),
    .ctl (dctl),
    .bin (mag),
    .bcd (bcd),
    .sts (dsts)
  );

  // The character register is full after a load and empties once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ch_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            upper <= (cmd == CMD_HEX32U);
            neg   <= (cmd == CMD_SDEC32) && value[31];
            case (cmd)
              CMD_SDEC32: begin
                ptr   <= TOP_DEC;
                state <= ST_CONV;
              end
              CMD_UDEC32: begin
                ptr   <= TOP_DEC;
                state <= ST_CONV;
              end
              CMD_HEX64L: begin
                digs  <= value;
                ptr   <= TOP_HEX64;
                state <= ST_SKIP;
              end
              CMD_HEX32L: begin
                digs  <= {32'b0, value[31:0]};
                ptr   <= TOP_HEX32;
                state <= ST_SKIP;
              end
              CMD_HEX32U: begin
                digs  <= {32'b0, value[31:0]};
                ptr   <= TOP_HEX32;
                state <= ST_SKIP;
              end
              default: begin
                // Unused selectors are taken and dropped without any character.
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CONV: begin
          // Wait for the shared shift-add-3 unit to finish its passes.
          if (dsts.done && !dsts.busy) begin
            digs  <= {{(64 - BCD_W){1'b0}}, bcd};
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // Walk down past leading zeros, keeping the units digit so zero prints as '0'.
          if (ptr != 4'd0 && cur == 4'd0) begin
            ptr <= ptr - 4'd1;
          end else begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            ch    <= CH_MINUS;
            last  <= 1'b0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            ch   <= digit_char(cur, upper);
            last <= (ptr == 4'd0);
            if (ptr == 4'd0) begin
              state <= ST_IDLE;
            end else begin
              ptr <= ptr - 4'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_integer_to_ascii_digits_core.sv =====
`timescale 1ns / 1ps

module tb_integer_to_ascii_digits_core;
  import i2a_pkg::*;

  // Selector codes that the block must ignore without emitting anything.
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 80;
  localparam int IDLE_PERCENT = 29;
  localparam int MAX_REPORTS  = 10;

  // One expected output transaction, with the number it came from for diagnostics.
  typedef struct {
    logic [7:0]  ch;
    logic        last;
    logic [2:0]  src_cmd;
    logic [63:0] src_value;
  } ascii_char_t;

  // Holds the characters still owed by the block and checks each one as it leaves.
  class char_tracker;
    ascii_char_t owed[$];
    int unsigned mismatches;

    function int pending();
      return owed.size();
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
    endfunction

    // Works out the text of one accepted number and queues its characters in order.
    function void note_number(logic [2:0] fmt, logic [63:0] num);
      logic [63:0] mag;
      logic [63:0] radix;
      logic [3:0]  dig;
      logic        neg;
      logic        upper;
      logic [7:0]  text[$];
      ascii_char_t item;
      neg   = 1'b0;
      upper = 1'b0;
      radix = 64'd16;
      case (fmt)
        CMD_SDEC32: begin
          // Negating the low word also covers the most negative value, whose
          // magnitude 2^31 still fits in 32 unsigned bits.
          neg   = num[31];
          mag   = neg ? {32'b0, ~num[31:0] + 32'd1} : {32'b0, num[31:0]};
          radix = 64'd10;
        end
        CMD_UDEC32: begin
          mag   = {32'b0, num[31:0]};
          radix = 64'd10;
        end
        CMD_HEX64L: mag = num;
        CMD_HEX32L: mag = {32'b0, num[31:0]};
        CMD_HEX32U: begin
          mag   = {32'b0, num[31:0]};
          upper = 1'b1;
        end
        default: return;
      endcase
      do begin
        dig = 4'(mag % radix);
        if (dig < 4'd10) text.push_front("0" + 8'(dig));
        else text.push_front((upper ? "A" : "a") + 8'(dig) - 8'd10);
        mag = mag / radix;
      end while (mag != 64'd0);
      if (neg) text.push_front("-");
      item.src_cmd   = fmt;
      item.src_value = num;
      foreach (text[i]) begin
        item.ch   = text[i];
        item.last = (i == text.size() - 1);
        owed.push_back(item);
      end
    endfunction

    function void check_char(logic [7:0] got_ch, logic got_last);
      ascii_char_t want;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected char %h last %b", got_ch, got_last));
        return;
      end
      want = owed.pop_front();
      if (got_ch !== want.ch || got_last !== want.last) begin
        flag($sformatf("cmd %0d value %h: got char %h last %b, expected char %h last %b",
                       want.src_cmd, want.src_value, got_ch, got_last, want.ch, want.last));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [63:0] value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  ch;
  logic        last;

  // Knobs that the stimulus thread sets for the two sides. A quiet side never idles.
  bit quiet_in;
  bit quiet_out;
  // The stimulus thread bumps this to ask the receiver for one long hold-off.
  int hold_requests;

  char_tracker sb = new();

  integer_to_ascii_digits_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ch        (ch),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing character ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_integer_to_ascii_digits_core NOT OK");
        $finish;
      end
    end
  end

  // Receiver. Every output transaction is checked against the oldest owed character.
  // Outputs are read right after the edge, before any register of the block updates,
  // so they hold the values that the edge itself sampled. The long hold-off is counted
  // here, in cycles, so the sender keeps offering numbers until the block backs up.
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall    = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_char(ch, last);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_out && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Offers one number and returns at the edge where the transaction is taken. A random
  // gap may come first. Valid is raised or kept high with exactly one assignment per
  // edge, and the payload stays put while the block stalls.
  task automatic send_number(input logic [2:0] fmt, input logic [63:0] num);
    int gap;
    gap = 0;
    if (!quiet_in) begin
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= fmt;
    value    <= num;
    do @(posedge clk); while (in_stall);
    sb.note_number(fmt, num);
  endtask

  // Sender pause: nothing is offered until the block has delivered everything it owes.
  // At least one edge passes, so valid is never assigned twice in one time step.
  task automatic wait_all_chars();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Sends n random numbers in the five real formats. Ignored selectors are mixed in
  // now and then but do not count toward n. Values lean toward small magnitudes,
  // the 32-bit sign boundary and powers of two, where digit counts change.
  task automatic send_random(input int n);
    int          sent;
    logic [2:0]  fmt;
    logic [63:0] num;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 6) fmt = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
      else fmt = 3'($urandom_range(CMD_HEX32U, CMD_SDEC32));
      case ($urandom_range(3))
        0: num = {$urandom, $urandom};
        1: num = {$urandom, 32'($urandom_range(20))};
        2: num = {$urandom, 32'h8000_0000 + 32'($urandom_range(4)) - 32'd2};
        default: num = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
      endcase
      if ($urandom_range(3) == 0) num = ~num;
      send_number(fmt, num);
      if (fmt <= CMD_HEX32U) sent++;
    end
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    cmd      = CMD_SDEC32;
    value    = 64'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: zero and the widest values of every format, the most negative
    // signed value, junk in the upper word of the 32-bit formats, and the ignored
    // selectors.
    send_number(CMD_SDEC32, 64'd0);
    send_number(CMD_SDEC32, 64'd1);
    send_number(CMD_SDEC32, 64'h0000_0000_ffff_ffff);
    send_number(CMD_SDEC32, 64'h0000_0000_7fff_ffff);
    send_number(CMD_SDEC32, 64'h0000_0000_8000_0000);
    send_number(CMD_SDEC32, 64'hdead_beef_0000_0123);
    send_number(CMD_SDEC32, 64'hffff_ffff_c465_3600);
    send_number(CMD_UDEC32, 64'd0);
    send_number(CMD_UDEC32, 64'h0000_0000_ffff_ffff);
    send_number(CMD_UDEC32, 64'hffff_ffff_ffff_ffff);
    send_number(CMD_UDEC32, 64'h8000_0000_3b9a_ca00);
    send_number(CMD_HEX64L, 64'd0);
    send_number(CMD_HEX64L, 64'hffff_ffff_ffff_ffff);
    send_number(CMD_HEX64L, 64'h0123_4567_89ab_cdef);
    send_number(CMD_HEX64L, 64'h8000_0000_0000_0000);
    send_number(CMD_HEX64L, 64'd1);
    send_number(CMD_HEX32L, 64'd0);
    send_number(CMD_HEX32L, 64'h5555_aaaa_ffff_ffff);
    send_number(CMD_HEX32L, 64'h0000_0000_00ab_cdef);
    send_number(CMD_HEX32U, 64'hffff_ffff_0000_0000);
    send_number(CMD_HEX32U, 64'h0000_0000_ffff_ffff);
    send_number(CMD_HEX32U, 64'h1234_5678_00ab_cdef);
    send_number(CMD_UNUSED_FIRST, 64'hffff_ffff_ffff_ffff);
    send_number(CMD_UNUSED_MID, {$urandom, $urandom});
    send_number(CMD_UNUSED_LAST, 64'd0);
    wait_all_chars();

    // Random part, in phases: a warm-up, a back-to-back stretch with neither side
    // idling, a stretch under a long receiver hold-off, a full drain, then the rest.
    send_random(40);
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    send_random(60);
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    hold_requests++;
    send_random(60);
    wait_all_chars();
    send_random(140);

    // Drain, then give the block time to show any character it should not send.
    // A character that never arrives is caught by the watchdog.
    wait_all_chars();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_integer_to_ascii_digits_core OK");
    end else begin
      $display("tb_integer_to_ascii_digits_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_dabble.sv
hw/rtl/integer_to_ascii_digits_core.sv
tb/tb_integer_to_ascii_digits_core.sv
